### hdl/hrms_pkg.sv
// Shared types and constants for the keyboard report sequencer.
package hrms_pkg;

    localparam int MODS_W     = 8;
    localparam int KEY_LANE_W = 56;
    localparam int KEY_LANES  = 4;
    localparam int NUM_STEPS  = 4;

    // Default depth of the command queue between front and back end.
    localparam int QUEUE_DEPTH = 2;

    // Report steps, in the order they go out.
    localparam int STEP_CLEAR = 0;  // released keys cleared, old modifiers
    localparam int STEP_PRESS = 1;  // newly pressed modifiers added
    localparam int STEP_KEYS  = 2;  // desired keys with current modifiers
    localparam int STEP_FINAL = 3;  // desired keys with desired modifiers

    typedef logic [MODS_W-1:0]                     t_mods;
    typedef logic [KEY_LANES-1:0][KEY_LANE_W-1:0]  t_keys;
    typedef logic [NUM_STEPS-1:0]                  t_steps;

    // One classified word: everything the back end needs to build its reports.
    typedef struct packed {
        t_steps steps;
        t_mods  old_mods;
        t_mods  cur_mods;
        t_mods  want_mods;
        t_keys  cur_keys;
        t_keys  want_keys;
    } t_cmd;

endpackage

### hdl/hrms_front.sv
// Front end: holds the last report sent and classifies each desired report.
module hrms_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  hrms_pkg::t_mods  i_mods,
    input  hrms_pkg::t_keys  i_keys,
    output hrms_pkg::t_cmd   o_cmd,
    output logic             o_cmd_valid
);

    hrms_pkg::t_mods r_sent_mods;
    hrms_pkg::t_keys r_sent_keys;

    hrms_pkg::t_mods pressed;
    hrms_pkg::t_mods released;
    hrms_pkg::t_keys gone;
    hrms_pkg::t_keys cur_keys;
    hrms_pkg::t_cmd  cmd;

    always_comb begin
        pressed  = (i_mods ^ r_sent_mods) & i_mods;
        released = (i_mods ^ r_sent_mods) & r_sent_mods;
        gone     = r_sent_keys & ~i_keys;
        // a modifier release drops released keys before anything else goes out
        cur_keys = (|released) ? (r_sent_keys & i_keys) : r_sent_keys;

        cmd.old_mods  = r_sent_mods;
        cmd.cur_mods  = (|pressed) ? (r_sent_mods | i_mods) : r_sent_mods;
        cmd.want_mods = i_mods;
        cmd.cur_keys  = cur_keys;
        cmd.want_keys = i_keys;
        cmd.steps[hrms_pkg::STEP_CLEAR] = (|released) && (|gone);
        cmd.steps[hrms_pkg::STEP_PRESS] = |pressed;
        cmd.steps[hrms_pkg::STEP_KEYS]  = (i_keys != cur_keys);
        cmd.steps[hrms_pkg::STEP_FINAL] = |released;
    end

    assign o_cmd       = cmd;
    assign o_cmd_valid = |cmd.steps;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sent_mods <= '0;
            r_sent_keys <= '0;
        end else if (i_accept) begin
            r_sent_mods <= i_mods;
            r_sent_keys <= i_keys;
        end
    end

endmodule

### hdl/hrms_queue.sv
// Short command queue between the front and back ends.
module hrms_queue #(
    parameter int DEPTH = hrms_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  hrms_pkg::t_cmd  i_cmd,
    input  logic            i_pop,
    output hrms_pkg::t_cmd  o_cmd,
    output logic            o_valid,
    output logic            o_full
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    hrms_pkg::t_cmd r_mem [DEPTH];
    logic [PW-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]  r_count,  n_count;

    logic do_push;
    logic do_pop;

    assign do_push = i_push && (r_count != FULL_CNT);
    assign do_pop  = i_pop && (r_count != '0);

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PW'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PW'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CW'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    assign o_cmd   = r_mem[r_rd_ptr];
    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == FULL_CNT);

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("queue count beyond depth");

    a_no_lost_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("word pushed into a full queue");

endmodule

### hdl/hrms_back.sv
// Back end: walks the pending steps of one word and sends one report a cycle while its output is free.
module hrms_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  hrms_pkg::t_cmd   i_cmd,
    input  logic             i_cmd_valid,
    output logic             o_cmd_pop,
    input  logic             i_pop,
    output logic             o_empty,
    output hrms_pkg::t_mods  o_mods,
    output hrms_pkg::t_keys  o_keys,
    output logic             o_last
);

    hrms_pkg::t_cmd   r_cmd,  n_cmd;
    hrms_pkg::t_steps r_pend, n_pend;

    logic             r_out_valid, n_out_valid;
    hrms_pkg::t_mods  r_out_mods,  n_out_mods;
    hrms_pkg::t_keys  r_out_keys,  n_out_keys;
    logic             r_out_last,  n_out_last;

    hrms_pkg::t_steps low_step;
    hrms_pkg::t_steps rest;
    hrms_pkg::t_mods  sel_mods;
    hrms_pkg::t_keys  sel_keys;
    logic             out_free;
    logic             emit;
    logic             load;

    always_comb begin
        low_step = r_pend & (~r_pend + hrms_pkg::t_steps'(1));
        rest     = r_pend & ~low_step;
        out_free = !r_out_valid || i_pop;
        emit     = (r_pend != '0) && out_free;
        load     = i_cmd_valid && ((r_pend == '0) || (emit && (rest == '0)));

        if (r_pend[hrms_pkg::STEP_CLEAR]) begin
            sel_mods = r_cmd.old_mods;
            sel_keys = r_cmd.cur_keys;
        end else if (r_pend[hrms_pkg::STEP_PRESS]) begin
            sel_mods = r_cmd.cur_mods;
            sel_keys = r_cmd.cur_keys;
        end else if (r_pend[hrms_pkg::STEP_KEYS]) begin
            sel_mods = r_cmd.cur_mods;
            sel_keys = r_cmd.want_keys;
        end else begin
            sel_mods = r_cmd.want_mods;
            sel_keys = r_cmd.want_keys;
        end

        n_cmd  = load ? i_cmd : r_cmd;
        n_pend = load ? i_cmd.steps : (emit ? rest : r_pend);

        n_out_valid = r_out_valid && !i_pop;
        n_out_mods  = r_out_mods;
        n_out_keys  = r_out_keys;
        n_out_last  = r_out_last;
        if (emit) begin
            n_out_valid = 1'b1;
            n_out_mods  = sel_mods;
            n_out_keys  = sel_keys;
            n_out_last  = (rest == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_out_mods <= n_out_mods;
        r_out_keys <= n_out_keys;
        r_out_last <= n_out_last;
    end

    assign o_cmd_pop = load;
    assign o_empty   = !r_out_valid;
    assign o_mods    = r_out_mods;
    assign o_keys    = r_out_keys;
    assign o_last    = r_out_last;

    a_stall_holds_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_pop && (r_pend != '0)) |=> $stable(r_pend))
        else $error("pending steps advanced while the output word was stalled");

    a_load_has_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |=> (r_pend != '0))
        else $error("loaded a word with no reports to send");

    a_load_only_when_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && (r_pend != '0)) |-> (emit && (rest == '0)))
        else $error("new word loaded over unfinished steps");

endmodule

### hdl/hid_report_modifier_sequencer_core.sv
// Top level of the keyboard report sequencer: front end, command queue, back end.
//
// Each desired keyboard report (modifier byte plus a 224-bit key bitmap) is compared
// with the last report sent and turns into zero to four reports, sent oldest first:
// released keys cleared under the old modifiers, newly pressed modifiers added, the
// new keys under the current modifiers, and the final modifiers. o_last_of_run marks
// the last report of a run; an input that changes nothing gives no report. An input
// word is taken in the cycle it arrives whenever the command queue (QUEUE_DEPTH words)
// has room; the front end updates its stored report at once, so words may follow
// each other every cycle. The back end sends one report per cycle through its output
// register while the output is empty or popped, and takes the next word as it sends
// the last report of a word, so runs follow with no gap. A word's first report goes
// through the queue, the back end's step register and the output register.
module hid_report_modifier_sequencer_core #(
    parameter int QUEUE_DEPTH = hrms_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_new_mods,
    input  logic [55:0] i_new_keys_0,
    input  logic [55:0] i_new_keys_1,
    input  logic [55:0] i_new_keys_2,
    input  logic [55:0] i_new_keys_3,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_out_mods,
    output logic [55:0] o_out_keys_0,
    output logic [55:0] o_out_keys_1,
    output logic [55:0] o_out_keys_2,
    output logic [55:0] o_out_keys_3,
    output logic        o_last_of_run
);

    hrms_pkg::t_keys in_keys;
    hrms_pkg::t_keys out_keys;
    hrms_pkg::t_cmd  front_cmd;
    hrms_pkg::t_cmd  head_cmd;
    logic            front_valid;
    logic            head_valid;
    logic            head_pop;
    logic            q_full;
    logic            accept;

    assign in_keys = {i_new_keys_3, i_new_keys_2, i_new_keys_1, i_new_keys_0};
    assign accept  = push && !q_full;
    assign full    = q_full;

    hrms_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_mods      (i_new_mods),
        .i_keys      (in_keys),
        .o_cmd       (front_cmd),
        .o_cmd_valid (front_valid)
    );

    hrms_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept && front_valid),
        .i_cmd   (front_cmd),
        .i_pop   (head_pop),
        .o_cmd   (head_cmd),
        .o_valid (head_valid),
        .o_full  (q_full)
    );

    hrms_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (head_cmd),
        .i_cmd_valid (head_valid),
        .o_cmd_pop   (head_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_mods      (o_out_mods),
        .o_keys      (out_keys),
        .o_last      (o_last_of_run)
    );

    assign o_out_keys_0 = out_keys[0];
    assign o_out_keys_1 = out_keys[1];
    assign o_out_keys_2 = out_keys[2];
    assign o_out_keys_3 = out_keys[3];

endmodule
